[rtl/core/lpe_pkg.sv]
package lpe_pkg;

  localparam int SENSOR_COUNT = 8;

  // Serial divider geometry: dividend magnitude and divisor magnitude
  localparam int DIV_DW = 40;
  localparam int DIV_VW = 19;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL,
    S_ROT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DGO,
    S_DWAIT,
    S_FIN,
    S_LOCK,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_PITCH     = 3'd1,
    REG_BLEND     = 3'd2,
    REG_EDGE      = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_LOCK      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic signed [9:0] OFFSET_ROM [SENSOR_COUNT] = '{
    -10'sd487, -10'sd284, -10'sd214, -10'sd345,
    -10'sd270, -10'sd163, -10'sd184, -10'sd369
  };

  localparam logic [2:0] SCAN_ORDER [SENSOR_COUNT] = '{
    3'd3, 3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd0, 3'd7
  };

endpackage

[rtl/core/lpe_div.sv]
module lpe_div #(
  parameter int DW = 40,
  parameter int VW = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [VW-1:0]         divisor,
  output lpe_pkg::div_stat_t    stat,
  output logic [DW-1:0]         quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = (cnt_r == CW'(1));
    if (start) begin
      cnt_nxt = CW'(DW);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // one quotient bit per cycle: shift in next dividend bit, trial subtract
      cnt_nxt = cnt_r - CW'(1);
      if (!diff[VW+1]) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[rtl/core/line_position_estimator_unit.sv]
// Channel | Dir | Transfer when           | Contents
// in_     | in  | in_tvalid & in_tready   | tuser op, tdata mask/ambients/proximity
// out_    | out | out_tvalid & out_tready | tdata found/position/flags/obstacle
// cfg_    | in  | cfg_valid & cfg_ready   | cfg_index register, cfg_data value
//
// A clear item goes straight to the result state; a frame with no line or an edge
// sensor skips the divider; an inner sensor takes up to two passes of the shared
// bit-serial divider.
// rst_n is synchronous and active low; it restores the register defaults.
// A held result in the output register does not block the next transfer in;
// only the final load waits for the output register to drain.
module line_position_estimator_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [0:0]    in_tuser,   // [0] op
  // [1:0] clear_mask, [17:2] ambient_s0 ... [129:114] ambient_s7,
  // [145:130] proximity_sample
  input  logic [151:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] line_found, [16:1] position_out, [17] on_line_flag,
  // [18] detected_flag, [34:19] obstacle_level
  output logic [39:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [17:0]   cfg_data
);

  localparam int NS = lpe_pkg::SENSOR_COUNT;
  localparam int DW = lpe_pkg::DIV_DW;
  localparam int VW = lpe_pkg::DIV_VW;

  lpe_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [17:0] thr_r;
  logic [10:0]        pitch_r, scale_r;
  logic [13:0]        edge_r;
  logic signed [10:0] coff_r;
  logic [7:0]         ftl_r;

  // persistent state
  logic [15:0]        avg_r, avg_nxt;
  logic [7:0]         lock_r, lock_nxt;
  logic [1:0]         flag_r, flag_nxt;
  logic signed [15:0] pos_r, pos_nxt;

  // per-item work registers
  logic signed [17:0] d_r [NS];
  logic signed [17:0] d_nxt [NS];
  logic [2:0]         c_r, c_nxt;
  logic [2:0]         rot_r, rot_nxt;
  logic               dir_r, dir_nxt;
  logic               found_r, found_nxt;
  logic signed [DW-1:0] num_r, num_nxt;
  logic signed [VW-1:0] dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic               phase_r, phase_nxt;
  logic signed [27:0] s_r, s_nxt;
  logic signed [39:0] t1_r, t1_nxt;
  logic [13:0]        cp_r, cp_nxt;
  logic signed [14:0] p_r, p_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [39:0]        out_data_r, out_data_nxt;

  // divider hookup
  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [VW-1:0]      div_dvs;
  logic [DW-1:0]      div_q;
  lpe_pkg::div_stat_t div_st;

  // combinational helpers
  logic               in_xfer;
  logic [NS-1:0]      lt;
  logic [2:0]         sel_c;
  logic               sel_found;
  logic signed [17:0] dl, dc, dr, dn;
  logic signed [18:0] den;
  logic signed [29:0] numer;
  logic [24:0]        base;
  logic signed [40:0] qs;
  logic signed [41:0] pw;
  logic signed [41:0] edge_w;
  logic [18:0]        avg_sum;
  logic               load_out;
  logic               lock_ok;

  lpe_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_st),
    .quotient (div_q)
  );

  function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
    if (v > 42'sd32767)       return 16'sh7fff;
    else if (v < -42'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  assign in_tready  = (state_r == lpe_pkg::S_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign load_out   = (state_r == lpe_pkg::S_DONE) && (!out_valid_r || out_tready);

  // sensor pick: last sensor in scan order strictly below threshold
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      lt[i] = (d_r[i] < thr_r);
    end
    sel_c = 3'd0;
    for (int k = 0; k < NS; k++) begin
      if (lt[lpe_pkg::SCAN_ORDER[k]]) sel_c = lpe_pkg::SCAN_ORDER[k];
    end
    sel_found = (|lt) || (d_r[0] == thr_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpe_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_tuser[0] == lpe_pkg::OP_CLEAR) ? lpe_pkg::S_DONE : lpe_pkg::S_SEL;
        end
      end
      lpe_pkg::S_SEL: begin
        if (!sel_found)                            state_nxt = lpe_pkg::S_DONE;
        else if (sel_c == 3'd0 || sel_c == 3'd7)   state_nxt = lpe_pkg::S_LOCK;
        else                                       state_nxt = lpe_pkg::S_ROT;
      end
      lpe_pkg::S_ROT:   if (rot_r == 3'd0) state_nxt = lpe_pkg::S_MUL1;
      lpe_pkg::S_MUL1:  state_nxt = (den == '0) ? lpe_pkg::S_MUL2 : lpe_pkg::S_DGO;
      lpe_pkg::S_MUL2:  state_nxt = lpe_pkg::S_MUL3;
      lpe_pkg::S_MUL3:  state_nxt = (scale_r == '0) ? lpe_pkg::S_FIN : lpe_pkg::S_DGO;
      lpe_pkg::S_DGO:   state_nxt = lpe_pkg::S_DWAIT;
      lpe_pkg::S_DWAIT: begin
        if (div_st.done) state_nxt = phase_r ? lpe_pkg::S_FIN : lpe_pkg::S_MUL2;
      end
      lpe_pkg::S_FIN:   state_nxt = lpe_pkg::S_LOCK;
      lpe_pkg::S_LOCK:  state_nxt = lpe_pkg::S_DONE;
      lpe_pkg::S_DONE:  if (load_out) state_nxt = lpe_pkg::S_IDLE;
      default:          state_nxt = lpe_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    avg_nxt       = avg_r;
    lock_nxt      = lock_r;
    flag_nxt      = flag_r;
    pos_nxt       = pos_r;
    d_nxt         = d_r;
    c_nxt         = c_r;
    rot_nxt       = rot_r;
    dir_nxt       = dir_r;
    found_nxt     = found_r;
    num_nxt       = num_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    phase_nxt     = phase_r;
    s_nxt         = s_r;
    t1_nxt        = t1_r;
    cp_nxt        = cp_r;
    p_nxt         = p_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dvd       = num_r[DW-1] ? DW'(-num_r) : DW'(num_r);
    div_dvs       = dvs_r[VW-1] ? VW'(-dvs_r) : VW'(dvs_r);

    // after rotation the chosen sensor sits at tap 1, its neighbors at 0 and 2
    dl     = d_r[0];
    dc     = d_r[1];
    dr     = d_r[2];
    dn     = (dr < dl) ? dr : dl;
    den    = {dc[17], dc} + {dn[17], dn};
    numer  = $signed({1'b0, scale_r}) * dn;
    base   = cp_r * scale_r;
    qs     = (scale_r == '0) ? 41'sd0 :
             (neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}));
    edge_w = $signed({28'd0, edge_r});
    pw     = 42'(qs) - edge_w + 42'(coff_r);
    avg_sum = {avg_r, 3'b000} - {3'b000, avg_r} + {3'b000, in_tdata[145:130]};
    lock_ok = !(edge_r == '0 && p_r == '0);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      lpe_pkg::S_IDLE: begin
        if (in_xfer) begin
          found_nxt = 1'b0;
          if (in_tuser[0] == lpe_pkg::OP_CLEAR) begin
            flag_nxt = flag_r & ~in_tdata[1:0];
          end else begin
            avg_nxt = avg_sum[18:3];
            for (int i = 0; i < NS; i++) begin
              d_nxt[i] = $signed({2'b00, in_tdata[2 + 16*i +: 16]})
                         - 18'(lpe_pkg::OFFSET_ROM[i]) - 18'sd1024;
            end
          end
        end
      end
      lpe_pkg::S_SEL: begin
        c_nxt     = sel_c;
        rot_nxt   = sel_c - 3'd1;
        found_nxt = sel_found;
        if (!sel_found) lock_nxt = '0;
        if (sel_c == 3'd7)      p_nxt = $signed({1'b0, edge_r});
        else if (sel_c == 3'd0) p_nxt = -$signed({1'b0, edge_r});
      end
      lpe_pkg::S_ROT: begin
        // rotate one place per cycle until the left neighbor reaches tap 0
        if (rot_r != 3'd0) begin
          for (int i = 0; i < NS; i++) begin
            d_nxt[i] = d_r[(i + 1) % NS];
          end
          rot_nxt = rot_r - 3'd1;
        end
      end
      lpe_pkg::S_MUL1: begin
        dir_nxt   = (dr < dl);
        num_nxt   = DW'(numer);
        dvs_nxt   = VW'(den);
        phase_nxt = 1'b0;
        s_nxt     = '0;
      end
      lpe_pkg::S_DGO: begin
        div_start = 1'b1;
        neg_nxt   = num_r[DW-1] ^ dvs_r[VW-1];
      end
      lpe_pkg::S_DWAIT: begin
        if (div_st.done && !phase_r) begin
          s_nxt = neg_r ? -$signed(div_q[27:0]) : $signed(div_q[27:0]);
        end
      end
      lpe_pkg::S_MUL2: begin
        t1_nxt = s_r * $signed({1'b0, pitch_r});
        cp_nxt = 14'(c_r * pitch_r);
      end
      lpe_pkg::S_MUL3: begin
        num_nxt   = $signed({15'd0, base}) + (dir_r ? t1_r : -t1_r);
        dvs_nxt   = $signed({8'd0, scale_r});
        phase_nxt = 1'b1;
      end
      lpe_pkg::S_FIN: begin
        pos_nxt = sat16(pw);
        if (pw > edge_w)       p_nxt = $signed({1'b0, edge_r});
        else if (pw < -edge_w) p_nxt = -$signed({1'b0, edge_r});
        else                   p_nxt = pw[14:0];
      end
      lpe_pkg::S_LOCK: begin
        if (lock_ok) begin
          if (lock_r < ftl_r) lock_nxt = lock_r + 8'd1;
        end else begin
          lock_nxt = '0;
        end
        if (lock_nxt == ftl_r) begin
          flag_nxt = 2'b11;
          pos_nxt  = 16'(p_r);
        end else begin
          flag_nxt = flag_r & 2'b10;
        end
      end
      lpe_pkg::S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, avg_r, flag_r[1], flag_r[0], pos_r, found_r};
        end
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpe_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
      pitch_r     <= 11'd128;
      scale_r     <= 11'd256;
      edge_r      <= 14'd448;
      coff_r      <= '0;
      ftl_r       <= 8'd2;
      avg_r       <= '0;
      lock_r      <= '0;
      flag_r      <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      avg_r       <= avg_nxt;
      lock_r      <= lock_nxt;
      flag_r      <= flag_nxt;
      pos_r       <= pos_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpe_pkg::REG_THRESHOLD: thr_r   <= cfg_data;
          lpe_pkg::REG_PITCH:     pitch_r <= cfg_data[10:0];
          lpe_pkg::REG_BLEND:     scale_r <= cfg_data[10:0];
          lpe_pkg::REG_EDGE:      edge_r  <= cfg_data[13:0];
          lpe_pkg::REG_OFFSET:    coff_r  <= cfg_data[10:0];
          lpe_pkg::REG_LOCK:      ftl_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    c_r        <= c_nxt;
    rot_r      <= rot_nxt;
    dir_r      <= dir_nxt;
    found_r    <= found_nxt;
    num_r      <= num_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    phase_r    <= phase_nxt;
    s_r        <= s_nxt;
    t1_r       <= t1_nxt;
    cp_r       <= cp_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == lpe_pkg::S_DWAIT))
    else $error("divider finished outside wait state");

  a_in_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != lpe_pkg::S_IDLE))
    else $error("accepted item did not start work");

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpe_pkg::S_ROT) |-> (rot_r < 3'd6))
    else $error("rotation count out of range");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule

[test/line_position_estimator_unit_tb.sv]
module line_position_estimator_unit_tb;

  localparam int FRAME_LIMIT = 1950;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  // One pending transfer into the block: op in tuser, the rest in tdata.
  typedef struct packed {
    logic             op;
    logic [1:0]       clear_mask;
    logic [7:0][15:0] ambient;
    logic [15:0]      proximity;
  } frame_t;

  // One predicted result.
  typedef struct {
    logic               line_found;
    logic signed [15:0] position;
    logic               on_line;
    logic               detected;
    logic [15:0]        obstacle;
  } estimate_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [0:0]    in_tuser;
  logic [151:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [39:0]   out_tdata;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [17:0]   cfg_data;

  line_position_estimator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow registers and state of the estimator.
  logic signed [17:0] thr_q;
  logic [10:0]        pitch_q;
  logic [10:0]        blend_q;
  logic [13:0]        edge_q;
  logic signed [10:0] trim_q;
  logic [7:0]         lock_target_q;
  logic [15:0]        avg_q;
  logic [7:0]         lock_cnt_q;
  logic [1:0]         flags_q;
  logic signed [15:0] pos_q;

  const int CAL_OFFSET [8] = '{-487, -284, -214, -345, -270, -163, -184, -369};
  const int SCAN_SEQ [8] = '{3, 4, 2, 5, 1, 6, 0, 7};

  frame_t    frame_q [$];
  estimate_t estimate_q [$];
  int        err_cnt = 0;
  int        frames_sent = 0;
  int        clears_sent = 0;
  int        found_seen = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  bit        hold_input;

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  task automatic reset_shadow();
    thr_q = '0;
    pitch_q = 11'd128;
    blend_q = 11'd256;
    edge_q = 14'd448;
    trim_q = '0;
    lock_target_q = 8'd2;
    avg_q = '0;
    lock_cnt_q = '0;
    flags_q = '0;
    pos_q = '0;
  endtask

  // Advance the shadow state by one transfer and return the expected result.
  function automatic estimate_t estimate_position(frame_t f);
    estimate_t r;
    longint d [8];
    longint emax, cval, p, scale, pa, pb, den, s, num;
    int c, n, k;
    r.line_found = 1'b0;
    if (f.op == lpe_pkg::OP_CLEAR) begin
      flags_q = flags_q & ~f.clear_mask;
    end else begin
      emax = edge_q;
      for (int i = 0; i < 8; i++)
        d[i] = longint'(f.ambient[i]) - CAL_OFFSET[i] - 1024;
      avg_q = 16'((32'(avg_q) * 7 + f.proximity) / 8);
      c = 0;
      cval = d[0];
      for (int i = 0; i < 8; i++) begin
        k = SCAN_SEQ[i];
        if (d[k] < longint'(thr_q)) begin
          cval = d[k];
          c = k;
        end
      end
      if (cval <= longint'(thr_q)) begin
        r.line_found = 1'b1;
        if (c == 7) begin
          p = emax;
        end else if (c == 0) begin
          p = -emax;
        end else begin
          scale = blend_q;
          pa = c * longint'(pitch_q);
          n = (d[c+1] < d[c-1]) ? c + 1 : c - 1;
          pb = n * longint'(pitch_q);
          den = d[c] + d[n];
          s = (den != 0) ? (scale * d[n]) / den : 0;
          num = pb * s + pa * (scale - s);
          p = (scale != 0) ? num / scale : 0;
          p = p - emax + longint'(trim_q);
          pos_q = sat16(p);
          if (p > emax) p = emax;
          if (p < -emax) p = -emax;
        end
        if (p < emax || p > -emax) begin
          if (lock_cnt_q < lock_target_q) lock_cnt_q = lock_cnt_q + 8'd1;
        end else begin
          lock_cnt_q = '0;
        end
        if (lock_cnt_q == lock_target_q) begin
          flags_q = 2'b11;
          pos_q = sat16(p);
        end else begin
          flags_q = flags_q & 2'b10;
        end
      end else begin
        lock_cnt_q = '0;
      end
    end
    r.position = pos_q;
    r.on_line = flags_q[0];
    r.detected = flags_q[1];
    r.obstacle = avg_q;
    return r;
  endfunction

  // Ambient value that gives a chosen difference for sensor i, kept in range.
  function automatic logic [15:0] ambient_for(int i, longint diff);
    longint a;
    a = diff + CAL_OFFSET[i] + 1024;
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    return a[15:0];
  endfunction

  function automatic frame_t clear_item(logic [1:0] mask);
    frame_t f;
    f = '0;
    f.op = lpe_pkg::OP_CLEAR;
    f.clear_mask = mask;
    for (int i = 0; i < 8; i++) f.ambient[i] = 16'($urandom);
    f.proximity = 16'($urandom);
    return f;
  endfunction

  // Build a frame with all sensors bright, then dark ones near the threshold.
  function automatic frame_t line_frame(int dark, int spread);
    frame_t f;
    int c;
    f = '0;
    f.op = lpe_pkg::OP_FRAME;
    f.clear_mask = 2'($urandom);
    for (int i = 0; i < 8; i++)
      f.ambient[i] = ambient_for(i, longint'(thr_q) + $urandom_range(1, spread));
    c = $urandom_range(0, 7);
    for (int j = 0; j < dark; j++) begin
      f.ambient[(c + j) % 8] =
        ambient_for((c + j) % 8, longint'(thr_q) - $urandom_range(0, spread));
    end
    f.proximity = 16'($urandom);
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f = '0;
    f.op = 1'($urandom_range(0, 1));
    f.clear_mask = 2'($urandom);
    for (int i = 0; i < 8; i++) f.ambient[i] = 16'($urandom);
    f.proximity = 16'($urandom);
    return f;
  endfunction

  // Drive one frame from the queue; hold valid across back-to-back transfers.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (frame_q.size() > 0 && !hold_input) begin
        frame_t f;
        f = frame_q.pop_front();
        estimate_q.push_back(estimate_position(f));
        in_tvalid <= 1'b1;
        in_tuser <= f.op;
        in_tdata <= {6'b0, f.proximity, f.ambient[7], f.ambient[6], f.ambient[5],
                     f.ambient[4], f.ambient[3], f.ambient[2], f.ambient[1],
                     f.ambient[0], f.clear_mask};
        if (f.op == lpe_pkg::OP_CLEAR) clears_sent <= clears_sent + 1;
        else frames_sent <= frames_sent + 1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The prediction is made when the driver launches an item; it must already
  // be in the queue when the block accepts it, which the launch order ensures.

  // Receiver stall pattern: alternate stretches of always-ready and random.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) out_tready <= 1'b1;
      else if (stall_phase < 200) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      estimate_t e;
      int bad;
      bad = 0;
      results_seen <= results_seen + 1;
      if (estimate_q.size() == 0) begin
        $error("result transfer with no prediction waiting: %h", out_tdata);
        bad++;
      end else begin
        e = estimate_q.pop_front();
        if (e.line_found) found_seen <= found_seen + 1;
        if (out_tdata[0] !== e.line_found) begin
          $error("line_found expected %0d actual %0d", e.line_found, out_tdata[0]);
          bad++;
        end
        if (out_tdata[16:1] !== e.position) begin
          $error("position_out expected %0d actual %0d", e.position,
                 $signed(out_tdata[16:1]));
          bad++;
        end
        if (out_tdata[17] !== e.on_line) begin
          $error("on_line_flag expected %0d actual %0d", e.on_line, out_tdata[17]);
          bad++;
        end
        if (out_tdata[18] !== e.detected) begin
          $error("detected_flag expected %0d actual %0d", e.detected, out_tdata[18]);
          bad++;
        end
        if (out_tdata[34:19] !== e.obstacle) begin
          $error("obstacle_level expected %0d actual %0d", e.obstacle,
                 out_tdata[34:19]);
          bad++;
        end
      end
      err_cnt <= err_cnt + bad;
    end
  end

  // Watchdog: count cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Wait until the block has nothing in flight.
  task automatic wait_idle();
    while (frame_q.size() > 0 || in_tvalid || estimate_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(lpe_pkg::cfg_reg_t idx, logic [17:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      lpe_pkg::REG_THRESHOLD: thr_q = value;
      lpe_pkg::REG_PITCH:     pitch_q = value[10:0];
      lpe_pkg::REG_BLEND:     blend_q = value[10:0];
      lpe_pkg::REG_EDGE:      edge_q = value[13:0];
      lpe_pkg::REG_OFFSET:    trim_q = value[10:0];
      lpe_pkg::REG_LOCK:      lock_target_q = value[7:0];
      default: ;
    endcase
  endtask

  task automatic random_settings(bit extreme);
    if (extreme) begin
      write_reg(lpe_pkg::REG_THRESHOLD, $urandom_range(0, 1) ? 18'h1ffff : 18'h20000);
      write_reg(lpe_pkg::REG_PITCH, $urandom_range(0, 1) ? 18'd1 : 18'd1024);
      write_reg(lpe_pkg::REG_BLEND, $urandom_range(0, 1) ? 18'd1 : 18'd1024);
      write_reg(lpe_pkg::REG_EDGE, $urandom_range(0, 1) ? 18'd0 : 18'd16383);
      write_reg(lpe_pkg::REG_OFFSET, $urandom_range(0, 1) ? 18'h3ff : 18'h400);
      write_reg(lpe_pkg::REG_LOCK, $urandom_range(0, 1) ? 18'd1 : 18'd255);
    end else begin
      write_reg(lpe_pkg::REG_THRESHOLD,
                18'($signed($urandom_range(0, 40000)) - 20000));
      write_reg(lpe_pkg::REG_PITCH, 18'($urandom_range(1, 1024)));
      write_reg(lpe_pkg::REG_BLEND, 18'($urandom_range(1, 1024)));
      write_reg(lpe_pkg::REG_EDGE, 18'($urandom_range(0, 16383)));
      write_reg(lpe_pkg::REG_OFFSET, 18'($signed($urandom_range(0, 2047)) - 1024));
      write_reg(lpe_pkg::REG_LOCK, 18'($urandom_range(1, 4)));
    end
  endtask

  initial begin
    frame_t f;
    int batch;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_input = 1'b0;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default settings, field extremes, both ops, edge and inner sensors.
    f = '0;
    frame_q.push_back(f);
    for (int i = 0; i < 8; i++) f.ambient[i] = 16'hffff;
    f.proximity = 16'hffff;
    frame_q.push_back(f);
    frame_q.push_back(f);
    // A single dark sensor at each position, including both edges.
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < 8; i++) f.ambient[i] = ambient_for(i, 500);
      f.ambient[c] = ambient_for(c, -100);
      f.proximity = 16'($urandom);
      frame_q.push_back(f);
    end
    // Equal neighbours and a zero divisor between sensor 3 and its neighbour.
    for (int i = 0; i < 8; i++) f.ambient[i] = ambient_for(i, 300);
    f.ambient[3] = ambient_for(3, -50);
    f.ambient[2] = ambient_for(2, 50);
    f.ambient[4] = ambient_for(4, 50);
    frame_q.push_back(f);
    frame_q.push_back(f);
    // Exactly at threshold: found but not chosen by the strict scan.
    for (int i = 0; i < 8; i++) f.ambient[i] = ambient_for(i, 10);
    f.ambient[0] = ambient_for(0, 0);
    frame_q.push_back(f);
    for (int m = 0; m < 4; m++) frame_q.push_back(clear_item(2'(m)));
    wait_idle();

    // Zero edge limit case with an exact zero position, then lock of one.
    write_reg(lpe_pkg::REG_EDGE, 18'd0);
    write_reg(lpe_pkg::REG_LOCK, 18'd1);
    for (int k = 0; k < 6; k++) frame_q.push_back(line_frame(2, 200));
    wait_idle();

    // Random phases, with extreme settings in every fourth phase and ordinary ones otherwise.
    batch = 0;
    while (frames_sent + clears_sent < FRAME_LIMIT) begin
      random_settings(batch % 4 == 3);
      for (int k = 0;
           k < 120 && frames_sent + clears_sent + frame_q.size() < FRAME_LIMIT;
           k++) begin
        case ($urandom_range(0, 9))
          0:       f = random_frame();
          1:       f = clear_item(2'($urandom));
          2, 3:    f = line_frame(1, 3000);
          default: f = line_frame($urandom_range(1, 3), 400);
        endcase
        frame_q.push_back(f);
      end
      // Hold input once per phase until every prediction has arrived.
      while (frame_q.size() > 60) @(posedge clk);
      hold_input = 1'b1;
      while (in_tvalid || estimate_q.size() > 0) @(posedge clk);
      hold_input = 1'b0;
      wait_idle();
      batch++;
    end

    $display("Covered %0d frames and %0d clear items over %0d setting phases,",
             frames_sent, clears_sent, batch);
    $display("with %0d line detections among %0d results.", found_seen, results_seen);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
